// ----- rtl/core/wdt_pkg.sv -----
// Shared types and constants of the watchdog timer register block.
package wdt_pkg;

  localparam int unsigned DATA_W = 32;

  // Item kinds carried in the mode field.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_LOAD    = 3'd0,
    REG_COUNT   = 3'd1,
    REG_CTRL    = 3'd2,
    REG_INT_STS = 3'd3,
    REG_RST_STS = 3'd4,
    REG_DISABLE = 3'd5
  } reg_idx_t;

  // Control register bit positions.
  localparam int unsigned CTL_ENABLE_BIT = 0;
  localparam int unsigned CTL_AUTO_BIT   = 1;
  localparam int unsigned CTL_IRQEN_BIT  = 2;
  localparam int unsigned CTL_WDOG_BIT   = 3;
  localparam int unsigned CTL_PRE_LSB    = 8;

  // Two-word sequence that leaves watchdog mode.
  localparam logic [DATA_W-1:0] SEQ_FIRST  = 32'h1234_5678;
  localparam logic [DATA_W-1:0] SEQ_SECOND = 32'h8765_4321;

  // Result of one item, handed from the core to the output register.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              interrupt_line;
    logic              reset_pulse;
  } wdt_result_t;

  // Live state bits exposed for checking.
  typedef struct packed {
    logic wdog;
    logic irq_en;
    logic event_flag;
    logic reset_flag;
  } wdt_status_t;

endpackage

// ----- rtl/core/wdt_core.sv -----
// Register file, prescaler and down counter of the watchdog timer.
module wdt_core #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  logic [1:0]           mode,
  input  logic [2:0]           reg_index,
  input  logic [31:0]          write_data,
  output wdt_pkg::wdt_result_t result,
  output wdt_pkg::wdt_status_t status
);
  import wdt_pkg::*;

  logic [COUNTER_WIDTH-1:0] load_r, load_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                     en_r, en_nxt;
  logic                     auto_r, auto_nxt;
  logic                     irqen_r, irqen_nxt;
  logic                     wdog_r, wdog_nxt;
  logic [7:0]               pre_r, pre_nxt;
  logic [7:0]               pcnt_r, pcnt_nxt;
  logic                     evt_r, evt_nxt;
  logic                     rstf_r, rstf_nxt;
  logic                     armed_r, armed_nxt;
  logic                     pulse;
  logic [DATA_W-1:0]        rd;
  logic [DATA_W-1:0]        ctl_word;
  logic [COUNTER_WIDTH-1:0] wr_cnt;

  assign ctl_word = {16'd0, pre_r, 4'd0, wdog_r, irqen_r, auto_r, en_r};
  assign wr_cnt   = write_data[COUNTER_WIDTH-1:0];

  always_comb begin
    load_nxt  = load_r;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    auto_nxt  = auto_r;
    irqen_nxt = irqen_r;
    wdog_nxt  = wdog_r;
    pre_nxt   = pre_r;
    pcnt_nxt  = pcnt_r;
    evt_nxt   = evt_r;
    rstf_nxt  = rstf_r;
    armed_nxt = armed_r;
    pulse     = 1'b0;
    rd        = '0;

    if (item_vld) begin
      case (mode)
        MODE_TICK: begin
          if (en_r) begin
            if (pcnt_r >= pre_r) begin
              pcnt_nxt = '0;
              // A step only acts on a nonzero counter; reaching zero expires.
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - COUNTER_WIDTH'(1);
                if (cnt_r == COUNTER_WIDTH'(1)) begin
                  if (wdog_r) begin
                    rstf_nxt = 1'b1;
                    pulse    = 1'b1;
                  end else begin
                    evt_nxt = 1'b1;
                    if (auto_r) begin
                      cnt_nxt = load_r;
                    end
                  end
                end
              end
            end else begin
              pcnt_nxt = pcnt_r + 8'd1;
            end
          end
        end
        MODE_READ: begin
          case (reg_index)
            REG_LOAD:    rd = DATA_W'(load_r);
            REG_COUNT:   rd = DATA_W'(cnt_r);
            REG_CTRL:    rd = ctl_word;
            REG_INT_STS: rd = DATA_W'(evt_r);
            REG_RST_STS: rd = DATA_W'(rstf_r);
            default:     rd = '0;
          endcase
        end
        MODE_WRITE: begin
          case (reg_index)
            REG_LOAD: begin
              load_nxt = wr_cnt;
              cnt_nxt  = wr_cnt;
            end
            REG_COUNT: cnt_nxt = wr_cnt;
            REG_CTRL: begin
              en_nxt    = write_data[CTL_ENABLE_BIT];
              auto_nxt  = write_data[CTL_AUTO_BIT];
              irqen_nxt = write_data[CTL_IRQEN_BIT];
              // Watchdog mode is sticky: a control write can only set it.
              wdog_nxt  = wdog_r | write_data[CTL_WDOG_BIT];
              pre_nxt   = write_data[CTL_PRE_LSB +: 8];
            end
            REG_INT_STS: begin
              if (write_data[0]) begin
                evt_nxt = 1'b0;
              end
            end
            REG_RST_STS: begin
              if (write_data[0]) begin
                rstf_nxt = 1'b0;
              end
            end
            REG_DISABLE: begin
              if (armed_r && (write_data == SEQ_SECOND)) begin
                wdog_nxt = 1'b0;
              end
              armed_nxt = (write_data == SEQ_FIRST);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r  <= '0;
      cnt_r   <= '0;
      en_r    <= 1'b0;
      auto_r  <= 1'b0;
      irqen_r <= 1'b0;
      wdog_r  <= 1'b0;
      pre_r   <= '0;
      pcnt_r  <= '0;
      evt_r   <= 1'b0;
      rstf_r  <= 1'b0;
      armed_r <= 1'b0;
    end else begin
      load_r  <= load_nxt;
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
      auto_r  <= auto_nxt;
      irqen_r <= irqen_nxt;
      wdog_r  <= wdog_nxt;
      pre_r   <= pre_nxt;
      pcnt_r  <= pcnt_nxt;
      evt_r   <= evt_nxt;
      rstf_r  <= rstf_nxt;
      armed_r <= armed_nxt;
    end
  end

  assign result.read_data      = rd;
  assign result.interrupt_line = evt_nxt & irqen_nxt;
  assign result.reset_pulse    = pulse;

  assign status.wdog       = wdog_r;
  assign status.irq_en     = irqen_r;
  assign status.event_flag = evt_r;
  assign status.reset_flag = rstf_r;

endmodule

// ----- rtl/core/watchdog_timer_registers_top.sv -----
// Top level of the watchdog timer: stream handshake and result register.
// Each input beat is one clock tick, one register read, one register write or an ignored
// item, and every beat yields exactly one result beat. The block takes one beat per cycle
// while its result register can drain: the register state is updated at the edge that
// accepts the beat, and the result is captured in an output register at that same edge.
// in_tready is high whenever that output register is empty or is being drained in the same
// cycle, so a stalled result holds the input side. The counter width follows COUNTER_WIDTH;
// reads of the load and counter registers are zero-extended to 32 bits.
module watchdog_timer_registers_top #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode[1:0], reg_index[4:2], write_data[36:5], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_data[31:0], interrupt_line[32], reset_pulse[33]
);
  import wdt_pkg::*;

  logic        in_acc;
  logic [1:0]  in_mode;
  logic [2:0]  in_idx;
  logic [31:0] in_wdata;

  wdt_result_t core_res;
  wdt_status_t core_sts;

  logic        out_vld_r, out_vld_nxt;
  wdt_result_t res_r;

  // Unpack the input beat.
  assign in_mode  = in_tdata[1:0];
  assign in_idx   = in_tdata[4:2];
  assign in_wdata = in_tdata[36:5];

  // A new beat is taken whenever the result register is free or emptying now.
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  wdt_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (in_acc),
    .mode       (in_mode),
    .reg_index  (in_idx),
    .write_data (in_wdata),
    .result     (core_res),
    .status     (core_sts)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (in_acc) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // The result payload needs no reset; it is qualified by out_vld_r.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= core_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res_r.reset_pulse, res_r.interrupt_line, res_r.read_data};

`ifndef SYNTH
  // A reported expiry leaves the reset status flag set until a later beat clears it.
  a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.reset_pulse) |-> core_sts.reset_flag)
    else $error("reset pulse reported without reset status flag");

  // Watchdog mode is only left through the second word of the disable sequence.
  a_wdog_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(core_sts.wdog) && $past(rst_n)) |->
      $past(in_acc && (in_mode == MODE_WRITE) && (in_idx == REG_DISABLE) &&
            (in_wdata == SEQ_SECOND)))
    else $error("watchdog mode cleared outside the disable sequence");

  // The interrupt line of the pending result matches the live flag and enable.
  a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.interrupt_line == (core_sts.event_flag && core_sts.irq_en)))
    else $error("interrupt line disagrees with event flag and enable");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the watchdog timer register block on its stream ports.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wdt_pkg::*;

  // The mode field has no named code for its fourth value; the block ignores it.
  localparam logic [1:0]  MODE_NONE     = 2'd3;
  // Register indexes past the disable register read as zero and ignore writes.
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
  // Control bits that a write can change; bits 7:4 always read as zero.
  localparam logic [15:0] CTRL_WRITABLE = 16'hFF0F;
  // Cycles of the long output stall, well past what the one-deep output register can absorb.
  localparam int          HOLD_CYCLES   = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // mode[1:0], reg_index[4:2], write_data[36:5], pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // read_data[31:0], interrupt_line[32], reset_pulse[33]

  // Idle mix of both sides, in cycles out of a hundred, and the long receiver stall.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic rx_hold = 1'b0;

  // Results that the register state predicts, oldest first.
  wdt_result_t expected_q[$];

  int errors = 0;
  int beats_sent = 0;
  int pulses_seen = 0;
  int irq_beats_seen = 0;

  // Predicted register state of the watchdog.
  logic [31:0] wd_load = '0;
  logic [31:0] wd_count = '0;
  logic [15:0] wd_ctrl = '0;
  logic [7:0]  wd_prescale = '0;
  logic        wd_event = 1'b0;
  logic        wd_rstflag = 1'b0;
  logic        wd_armed = 1'b0;

  watchdog_timer_registers_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // The receiver drops ready at random per the current idle mix, and holds it low throughout
  // while the long stall is in force.
  always @(posedge clk) begin
    out_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Applies one accepted beat to the predicted state and returns the result it should give.
  // The counter runs at the full 32 bits, so no masking is needed on loads or decrements.
  function automatic wdt_result_t apply_beat(input logic [1:0] mode, input logic [2:0] idx,
                                             input logic [31:0] data);
    wdt_result_t r;
    r = '0;
    case (mode)
      MODE_TICK: begin
        // A tick only counts while enabled; a run of prescaler+1 ticks makes one step.
        if (wd_ctrl[CTL_ENABLE_BIT]) begin
          if (wd_prescale >= wd_ctrl[CTL_PRE_LSB +: 8]) begin
            wd_prescale = '0;
            // A counter already at zero stays put and does not expire again.
            if (wd_count != 0) begin
              wd_count = wd_count - 32'd1;
              if (wd_count == 0) begin
                if (wd_ctrl[CTL_WDOG_BIT]) begin
                  wd_rstflag = 1'b1;
                  r.reset_pulse = 1'b1;
                end else begin
                  wd_event = 1'b1;
                  if (wd_ctrl[CTL_AUTO_BIT]) wd_count = wd_load;
                end
              end
            end
          end else begin
            wd_prescale = wd_prescale + 8'd1;
          end
        end
      end
      MODE_READ: begin
        case (idx)
          REG_LOAD:    r.read_data = wd_load;
          REG_COUNT:   r.read_data = wd_count;
          REG_CTRL:    r.read_data = {16'h0000, wd_ctrl};
          REG_INT_STS: r.read_data = {31'd0, wd_event};
          REG_RST_STS: r.read_data = {31'd0, wd_rstflag};
          default:     r.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        case (idx)
          REG_LOAD: begin
            wd_load  = data;
            wd_count = data;
          end
          REG_COUNT: wd_count = data;
          // Watchdog mode can be switched on here but never off.
          REG_CTRL: wd_ctrl = (data[15:0] & CTRL_WRITABLE) | (wd_ctrl & (16'd1 << CTL_WDOG_BIT));
          REG_INT_STS: if (data[0]) wd_event = 1'b0;
          REG_RST_STS: if (data[0]) wd_rstflag = 1'b0;
          REG_DISABLE: begin
            if (data == SEQ_SECOND && wd_armed) wd_ctrl[CTL_WDOG_BIT] = 1'b0;
            wd_armed = (data == SEQ_FIRST);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.interrupt_line = wd_event & wd_ctrl[CTL_IRQEN_BIT];
    return r;
  endfunction

  function automatic logic [31:0] ctrl_word(input logic [7:0] pre, input logic wd,
                                            input logic ie, input logic ar, input logic en);
    ctrl_word = '0;
    ctrl_word[CTL_PRE_LSB +: 8] = pre;
    ctrl_word[CTL_WDOG_BIT]     = wd;
    ctrl_word[CTL_IRQEN_BIT]    = ie;
    ctrl_word[CTL_AUTO_BIT]     = ar;
    ctrl_word[CTL_ENABLE_BIT]   = en;
  endfunction

  // Offers one beat after a random idle gap and holds it until the block takes it. Valid is
  // left high on return so that back-to-back beats never lower and raise it in one step.
  task automatic send_beat(input logic [1:0] mode, input logic [2:0] idx,
                           input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, data, idx, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(apply_beat(mode, idx, data));
    beats_sent++;
  endtask

  // Every accepted result beat is matched against the oldest prediction, field by field.
  always @(posedge clk) begin
    wdt_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_tdata);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_tdata[31:0] !== exp_res.read_data) begin
          $display("%0t: read_data expected %h, got %h", $time, exp_res.read_data,
                   out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[32] !== exp_res.interrupt_line) begin
          $display("%0t: interrupt_line expected %b, got %b", $time, exp_res.interrupt_line,
                   out_tdata[32]);
          errors++;
        end
        if (out_tdata[33] !== exp_res.reset_pulse) begin
          $display("%0t: reset_pulse expected %b, got %b", $time, exp_res.reset_pulse,
                   out_tdata[33]);
          errors++;
        end
        if (out_tdata[33] === 1'b1) pulses_seen++;
        if (out_tdata[32] === 1'b1) irq_beats_seen++;
      end
    end
  end

  // Reset values, full-width load, reserved control bits, spare indexes and the ignored mode.
  task automatic test_register_access;
    send_beat(MODE_READ, REG_LOAD, '0);
    send_beat(MODE_READ, REG_COUNT, '0);
    send_beat(MODE_READ, REG_CTRL, '0);
    send_beat(MODE_READ, REG_INT_STS, '0);
    send_beat(MODE_READ, REG_RST_STS, '0);
    send_beat(MODE_WRITE, REG_LOAD, 32'hFFFF_FFFF);
    send_beat(MODE_READ, REG_COUNT, '0);
    send_beat(MODE_WRITE, REG_COUNT, '0);
    // All bits but watchdog mode: the reserved nibble and upper half must read back as zero.
    send_beat(MODE_WRITE, REG_CTRL, 32'hFFFF_FFF7);
    send_beat(MODE_READ, REG_CTRL, '0);
    send_beat(MODE_WRITE, REG_CTRL, '0);
    send_beat(MODE_WRITE, REG_SPARE_HI, 32'hFFFF_FFFF);
    send_beat(MODE_READ, REG_SPARE_LO, '0);
    send_beat(MODE_NONE, REG_SPARE_HI, 32'hFFFF_FFFF);
    send_beat(MODE_READ, REG_DISABLE, '0);
  endtask

  // Timer-mode expiry with and without auto-reload, status clearing and disabled ticks.
  task automatic test_timer_expiry;
    send_beat(MODE_WRITE, REG_LOAD, 32'd2);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    repeat (3) send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_READ, REG_INT_STS, '0);
    // Only bit 0 of a status write matters.
    send_beat(MODE_WRITE, REG_INT_STS, 32'hFFFF_FFFE);
    send_beat(MODE_WRITE, REG_INT_STS, 32'd1);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    repeat (3) send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_WRITE, REG_CTRL, '0);
    send_beat(MODE_WRITE, REG_COUNT, 32'd1);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_READ, REG_COUNT, '0);
  endtask

  // Largest prescaler, then a prescaler lowered below the running prescale count.
  task automatic test_prescaler;
    send_beat(MODE_WRITE, REG_COUNT, 32'd2);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
    repeat (4) send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_READ, REG_COUNT, '0);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'd2, 1'b0, 1'b0, 1'b0, 1'b1));
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_READ, REG_COUNT, '0);
  endtask

  // Watchdog expiry, the sticky mode bit and the two-word disable sequence.
  task automatic test_watchdog_disable;
    send_beat(MODE_WRITE, REG_LOAD, 32'd1);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'd0, 1'b1, 1'b1, 1'b0, 1'b1));
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_READ, REG_RST_STS, '0);
    send_beat(MODE_WRITE, REG_CTRL, ctrl_word(8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
    // Second word alone, and a broken sequence, must leave watchdog mode set.
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_SECOND);
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_FIRST);
    send_beat(MODE_WRITE, REG_DISABLE, '0);
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_SECOND);
    send_beat(MODE_READ, REG_CTRL, '0);
    // A repeated first word keeps the sequence armed.
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_FIRST);
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_FIRST);
    send_beat(MODE_WRITE, REG_DISABLE, SEQ_SECOND);
    send_beat(MODE_READ, REG_CTRL, '0);
    send_beat(MODE_WRITE, REG_RST_STS, 32'd1);
    send_beat(MODE_READ, REG_RST_STS, '0);
  endtask

  // Mostly ticks with small loads and prescalers so that expiries come often, mixed with
  // reads, writes of every kind, disable sequences whole and broken, and ignored items.
  task automatic test_random_traffic(input int n_beats);
    int          pick;
    logic [31:0] data;
    repeat (n_beats) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_beat(MODE_TICK, 3'($urandom_range(7)), $urandom);
      end else if (pick < 72) begin
        send_beat(MODE_READ, 3'($urandom_range(7)), $urandom);
      end else if (pick < 97) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          data = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
          send_beat(MODE_WRITE, REG_LOAD, data);
        end else if (pick < 30) begin
          data = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
          send_beat(MODE_WRITE, REG_COUNT, data);
        end else if (pick < 55) begin
          data = $urandom;
          data[CTL_PRE_LSB +: 8] = ($urandom_range(99) < 70) ? 8'($urandom_range(2))
                                                             : 8'($urandom_range(255));
          data[CTL_ENABLE_BIT] = ($urandom_range(99) < 85);
          data[CTL_WDOG_BIT]   = ($urandom_range(99) < 10);
          send_beat(MODE_WRITE, REG_CTRL, data);
        end else if (pick < 65) begin
          send_beat(MODE_WRITE, REG_INT_STS, $urandom);
        end else if (pick < 75) begin
          send_beat(MODE_WRITE, REG_RST_STS, $urandom);
        end else if (pick < 95) begin
          pick = $urandom_range(99);
          if (pick < 30) begin
            send_beat(MODE_WRITE, REG_DISABLE, SEQ_FIRST);
            send_beat(MODE_WRITE, REG_DISABLE, SEQ_SECOND);
          end else if (pick < 55) begin
            send_beat(MODE_WRITE, REG_DISABLE, SEQ_FIRST);
          end else if (pick < 80) begin
            send_beat(MODE_WRITE, REG_DISABLE, SEQ_SECOND);
          end else begin
            send_beat(MODE_WRITE, REG_DISABLE, $urandom);
          end
        end else begin
          send_beat(MODE_WRITE, $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        end
      end else begin
        send_beat(MODE_NONE, 3'($urandom_range(7)), $urandom);
      end
    end
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering beats, so the
  // output register fills and the block must hold off its input without losing anything.
  task automatic test_output_stall;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    test_random_traffic(40);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cases run with the first idle mix so that gaps already hit them.
    send_idle_pct = 26;
    recv_idle_pct = 65;
    test_register_access;
    test_timer_expiry;
    test_prescaler;
    test_watchdog_disable;
    test_output_stall;

    send_idle_pct = 26;
    recv_idle_pct = 65;
    test_random_traffic(560);
    send_idle_pct = 65;
    recv_idle_pct = 26;
    test_random_traffic(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // Keep clocking so that any stray result beat still gets caught.
    repeat (8) @(posedge clk);

    $display("Covered %0d beats of register access, expiry, prescaling and disable sequences,",
             beats_sent);
    $display("random traffic under three idle mixes and a long stall (%0d pulses, %0d irq).",
             pulses_seen, irq_beats_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard limit, far beyond what a correct run takes.
  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
